// File: src/semver_text_parser_assert.svh
// Assertion macros shared by the checker of the version text parser.
// No dependencies; include by bare file name.
`ifndef SEMVER_TEXT_PARSER_ASSERT_SVH
`define SEMVER_TEXT_PARSER_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define SVP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define SVP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/svp_pkg.sv
// Shared types and constants of the version text parser.
// No dependencies; imported by every design module of the block.
`default_nettype none

package svp_pkg;

  localparam int unsigned MaxTextBytes  = 32;
  localparam int unsigned CntW          = $clog2(MaxTextBytes + 1);
  localparam int unsigned PartMaxDigits = 5;
  localparam int unsigned PartMaxValue  = 65535;
  localparam int unsigned ValW          = 16;

  localparam logic [7:0] DotChar  = 8'h2E;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // Class of one text character, decided by the front end.
  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_DOT   = 2'd1,
    CLS_OTHER = 2'd2
  } char_cls_e;

  // Classified character handed from the front end to the back end.
  typedef struct packed {
    char_cls_e  cls;
    logic [3:0] digit;
    logic       last;
  } item_t;

  // One finished result.
  typedef struct packed {
    logic            accepted;
    logic [ValW-1:0] major;
    logic [ValW-1:0] minor;
    logic [ValW-1:0] patch;
  } result_t;

endpackage

`default_nettype wire

// File: src/svp_front.sv
// Front end: takes characters and registers them with their class.
// Depends on svp_pkg.
`default_nettype none

module svp_front import svp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] character_i,
  input  wire logic       last_char_i,
  output logic            valid_o,
  output item_t           item_o,
  input  wire logic       ready_i
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign full  = valid_q && !ready_i;
  assign take  = push && !full;

  always_comb begin
    item_d       = item_q;
    item_d.last  = last_char_i;
    item_d.digit = 4'(character_i - CharZero);
    if (character_i == DotChar) begin
      item_d.cls = CLS_DOT;
    end else if (character_i >= CharZero && character_i <= CharNine) begin
      item_d.cls = CLS_DIGIT;
    end else begin
      item_d.cls = CLS_OTHER;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: src/svp_queue.sv
// Two-entry queue of classified characters between front and back end.
// Depends on svp_pkg.
`default_nettype none

module svp_queue import svp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_valid_i,
  input  wire item_t wr_item_i,
  output logic       wr_ready_o,
  output logic       rd_valid_o,
  output item_t      rd_item_o,
  input  wire logic  rd_ready_i
);

  item_t       mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic        wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_item_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) begin
        wptr_q <= !wptr_q;
      end
      if (rd) begin
        rptr_q <= !rptr_q;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

// File: src/svp_back.sv
// Back end: parse state per character and a two-entry result queue.
// Depends on svp_pkg.
`default_nettype none

module svp_back import svp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire item_t item_i,
  output logic       ready_o,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      part_q, part_d;
  logic [2:0]      dig_q, dig_d;
  logic [ValW-1:0] run_q, run_d;
  logic [ValW-1:0] maj_q, maj_d;
  logic [ValW-1:0] min_q, min_d;
  logic            fail_q, fail_d;

  logic [ValW+3:0] prod;
  logic            take;
  logic            ok;
  logic            res_push;
  result_t         res_d;

  result_t         res_mem_q [2];
  logic            res_wptr_q, res_rptr_q;
  logic [1:0]      res_cnt_q;
  logic            res_pop;

  assign ready_o = (res_cnt_q != 2'd2);
  assign take    = valid_i && ready_o;

  // Next value of the current part: value * 10 + digit.
  assign prod = ({1'b0, run_q, 3'b000} + {3'b000, run_q, 1'b0}) + {(ValW)'(0), item_i.digit};

  always_comb begin
    cnt_d    = cnt_q;
    part_d   = part_q;
    dig_d    = dig_q;
    run_d    = run_q;
    maj_d    = maj_q;
    min_d    = min_q;
    fail_d   = fail_q;
    ok       = 1'b0;
    res_push = 1'b0;
    res_d    = '0;
    if (take) begin
      if (cnt_q >= CntW'(MaxTextBytes)) begin
        fail_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (!fail_q) begin
          case (item_i.cls)
            CLS_DOT: begin
              if (dig_q == 3'd0 || part_q >= 2'd2) begin
                fail_d = 1'b1;
              end else begin
                if (part_q == 2'd0) begin
                  maj_d = run_q;
                end else begin
                  min_d = run_q;
                end
                part_d = part_q + 2'd1;
                run_d  = '0;
                dig_d  = 3'd0;
              end
            end
            CLS_DIGIT: begin
              if (dig_q == 3'd1 && run_q == '0) begin
                fail_d = 1'b1;
              end else if (dig_q >= 3'(PartMaxDigits)) begin
                fail_d = 1'b1;
              end else if (prod > (ValW + 4)'(PartMaxValue)) begin
                fail_d = 1'b1;
              end else begin
                run_d = prod[ValW-1:0];
                dig_d = dig_q + 3'd1;
              end
            end
            default: begin
              fail_d = 1'b1;
            end
          endcase
        end
      end
      if (item_i.last) begin
        ok             = !fail_d && dig_d != 3'd0 && part_d == 2'd2;
        res_push       = 1'b1;
        res_d.accepted = ok;
        res_d.major    = ok ? maj_d : '0;
        res_d.minor    = ok ? min_d : '0;
        res_d.patch    = ok ? run_d : '0;
        cnt_d  = '0;
        part_d = 2'd0;
        dig_d  = 3'd0;
        run_d  = '0;
        maj_d  = '0;
        min_d  = '0;
        fail_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      part_q <= 2'd0;
      dig_q  <= 3'd0;
      run_q  <= '0;
      maj_q  <= '0;
      min_q  <= '0;
      fail_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      part_q <= part_d;
      dig_q  <= dig_d;
      run_q  <= run_d;
      maj_q  <= maj_d;
      min_q  <= min_d;
      fail_q <= fail_d;
    end
  end

  // Result queue.
  assign empty    = (res_cnt_q == 2'd0);
  assign res_pop  = pop && !empty;
  assign result_o = res_mem_q[res_rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wptr_q <= 1'b0;
      res_rptr_q <= 1'b0;
      res_cnt_q  <= 2'd0;
    end else begin
      if (res_push) begin
        res_wptr_q <= !res_wptr_q;
      end
      if (res_pop) begin
        res_rptr_q <= !res_rptr_q;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wptr_q] <= res_d;
    end
  end

endmodule

`default_nettype wire

// File: src/semver_text_parser.sv
// Version text parser: checks "MAJOR.MINOR.PATCH" text that arrives one
// character per word, with the final character flagged by last_char_i. Each
// part must have 1 to 5 digits, no leading zero and a value of at most
// 65535; the text may hold at most 32 characters. One result word comes out
// per text, after its final character: accepted_o plus the three values,
// which are zero when the text is rejected. The block takes one character
// per clock cycle for as long as the result side keeps up; that rate is set
// by the back end, which updates the part value (a multiply by ten and an
// add) once per cycle. A result passes the classifying input register, the
// two-word queue and the two-word result queue on its way to the result
// ports; the back end writes it into its result queue at the edge where it
// takes that character.
// Depends on svp_pkg, svp_front, svp_queue and svp_back.
`default_nettype none

module semver_text_parser import svp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  character_i,
  input  wire logic        last_char_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             accepted_o,
  output logic [15:0]      major_value_o,
  output logic [15:0]      minor_value_o,
  output logic [15:0]      patch_value_o
);

  // Front end to queue.
  logic    fq_valid, fq_ready;
  item_t   fq_item;
  // Queue to back end.
  logic    qb_valid, qb_ready;
  item_t   qb_item;
  result_t result;

  // The front end classifies each character as digit, dot or other and keeps
  // it in a register; full is decoded from that register and the queue's count.
  svp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .character_i (character_i),
    .last_char_i (last_char_i),
    .valid_o     (fq_valid),
    .item_o      (fq_item),
    .ready_i     (fq_ready)
  );

  // A short queue lets the front end keep taking words while the back end
  // waits for room in its result queue.
  svp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_item_i  (fq_item),
    .wr_ready_o (fq_ready),
    .rd_valid_o (qb_valid),
    .rd_item_o  (qb_item),
    .rd_ready_i (qb_ready)
  );

  // The back end holds the parse state, checks every rule, and on the final
  // character writes the result word and clears its state for the next text.
  svp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (qb_valid),
    .item_i   (qb_item),
    .ready_o  (qb_ready),
    .empty    (empty),
    .pop      (pop),
    .result_o (result)
  );

  assign accepted_o    = result.accepted;
  assign major_value_o = result.major;
  assign minor_value_o = result.minor;
  assign patch_value_o = result.patch;

endmodule

`default_nettype wire

// File: src/svp_checker.sv
// Port-level checks of the version text parser, bound to the top level.
// Depends on semver_text_parser_assert.svh and semver_text_parser.
`default_nettype none
`include "semver_text_parser_assert.svh"

module svp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        accepted_o,
  input wire logic [15:0] major_value_o,
  input wire logic [15:0] minor_value_o,
  input wire logic [15:0] patch_value_o
);

  logic        vals_zero;
  logic [48:0] res_word;

  assign vals_zero = (major_value_o == 16'd0) && (minor_value_o == 16'd0) &&
                     (patch_value_o == 16'd0);
  assign res_word  = {accepted_o, major_value_o, minor_value_o, patch_value_o};

  // A rejected text reports all three values as zero.
  `SVP_ASSERT(a_reject_zero, clk_i, rst_ni, !empty && !accepted_o |-> vals_zero, "rejected result carries nonzero values")

  // While reset is held, no result word is offered and the input is open.
  `SVP_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> empty && !full, "busy during reset")

  // A waiting result holds until it is taken.
  `SVP_ASSERT(a_result_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(res_word), "waiting result changed")

  // The result side only drains when a word is taken.
  `SVP_ASSERT(a_empty_by_pop, clk_i, rst_ni, $rose(empty) |-> $past(pop), "result vanished without pop")

endmodule

bind semver_text_parser svp_checker u_svp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .accepted_o    (accepted_o),
  .major_value_o (major_value_o),
  .minor_value_o (minor_value_o),
  .patch_value_o (patch_value_o)
);

`default_nettype wire
